>>> rtl/rbc_pkg.sv
// Shared types, constants and helpers for the reconnect backoff controller.
// No dependencies; the design files refer to this package by scoped names, the testbench imports it.
package rbc_pkg;

  localparam int unsigned DelayBits = 24;
  localparam int unsigned CountBits = 8;
  localparam int unsigned ShiftBits = $clog2(DelayBits);
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 24;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // Link state codes.
  localparam logic [1:0] LinkDisc = 2'd0;
  localparam logic [1:0] LinkConnecting = 2'd1;
  localparam logic [1:0] LinkConnected = 2'd2;
  localparam logic [1:0] LinkReconn = 2'd3;

  // Item command codes.
  localparam logic CmdReport = 1'b0;
  localparam logic CmdTick = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] RegAutoEnable = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegServerKnown = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegInitialDelay = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegMaxDelay = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegMaxAttempts = 3'd4;

  typedef enum logic [2:0] {
    EvNone = 3'd0,
    EvScheduled = 3'd1,
    EvLimit = 3'd2,
    EvReconnect = 3'd3,
    EvConnected = 3'd4
  } event_e;

  typedef struct packed {
    logic cmd;
    logic [1:0] new_state;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] attempt_number;
    logic [DelayBits-1:0] retry_delay;
    logic [1:0] link_state;
  } out_item_t;

  typedef struct packed {
    logic auto_enable;
    logic server_known;
    logic [DelayBits-1:0] initial_delay;
    logic [DelayBits-1:0] max_delay;
    logic [7:0] max_attempts;
  } cfg_t;

  function automatic logic [CountBits-1:0] sat_inc(input logic [CountBits-1:0] v);
    return (v == CountMax) ? CountMax : v + 1'b1;
  endfunction

endpackage

>>> rtl/rbc_in_if.sv
// Input channel of the reconnect backoff controller: valid, ready and one item.
// Depends on rbc_pkg for the item type.
interface rbc_in_if;
  logic valid;
  logic ready;
  rbc_pkg::in_item_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

>>> rtl/rbc_out_if.sv
// Result channel of the reconnect backoff controller: valid, ready and one result.
// Depends on rbc_pkg for the result type.
interface rbc_out_if;
  logic valid;
  logic ready;
  rbc_pkg::out_item_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

>>> rtl/rbc_cfg.sv
// Configuration register file of the reconnect backoff controller.
// Depends on rbc_pkg for register indexes and the configuration struct.
module rbc_cfg (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [rbc_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [rbc_pkg::CfgDataBits-1:0] cfg_wdata_i,
  output rbc_pkg::cfg_t cfg_o
);

  rbc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbc_pkg::RegAutoEnable: cfg_d.auto_enable = cfg_wdata_i[0];
        rbc_pkg::RegServerKnown: cfg_d.server_known = cfg_wdata_i[0];
        rbc_pkg::RegInitialDelay: cfg_d.initial_delay = cfg_wdata_i[rbc_pkg::DelayBits-1:0];
        rbc_pkg::RegMaxDelay: cfg_d.max_delay = cfg_wdata_i[rbc_pkg::DelayBits-1:0];
        rbc_pkg::RegMaxAttempts: cfg_d.max_attempts = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_enable <= 1'b1;
      cfg_q.server_known <= 1'b0;
      cfg_q.initial_delay <= rbc_pkg::DelayBits'(5000);
      cfg_q.max_delay <= rbc_pkg::DelayBits'(30000);
      cfg_q.max_attempts <= 8'd5;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/rbc_delay.sv
// Backoff delay for the next retry: initial delay as is with no earlier attempt, else
// doubled per earlier attempt after the first and clamped to the maximum. Depends on rbc_pkg for widths.
module rbc_delay (
  input  logic [rbc_pkg::CountBits-1:0] attempt_count_i,
  input  logic [rbc_pkg::DelayBits-1:0] initial_delay_i,
  input  logic [rbc_pkg::DelayBits-1:0] max_delay_i,
  output logic [rbc_pkg::DelayBits-1:0] delay_o
);

  logic [rbc_pkg::CountBits-1:0] shift_amt;
  logic [2*rbc_pkg::DelayBits-1:0] grown;
  logic shift_too_far;

  assign shift_amt = attempt_count_i - 1'b1;
  assign shift_too_far = 32'(shift_amt) >= 32'(rbc_pkg::DelayBits);
  // The result is used only when the shift stays below DelayBits, so the double-width word cannot overflow there.
  assign grown = {{rbc_pkg::DelayBits{1'b0}}, initial_delay_i}
                 << shift_amt[rbc_pkg::ShiftBits-1:0];

  always_comb begin
    if (attempt_count_i == '0) begin
      delay_o = initial_delay_i;
    end else if (initial_delay_i == '0) begin
      delay_o = '0;
    end else if (shift_too_far) begin
      delay_o = max_delay_i;
    end else if (grown < {{rbc_pkg::DelayBits{1'b0}}, max_delay_i}) begin
      delay_o = grown[rbc_pkg::DelayBits-1:0];
    end else begin
      delay_o = max_delay_i;
    end
  end

endmodule

>>> rtl/rbc_core.sv
// Link state, attempt counter and retry countdown; computes one result per item.
// Depends on rbc_pkg and instantiates rbc_delay.
module rbc_core (
  input  logic clk_i,
  input  logic rst_ni,
  input  rbc_pkg::cfg_t cfg_i,
  input  logic fire_i,
  input  rbc_pkg::in_item_t item_i,
  output rbc_pkg::out_item_t result_o
);

  logic [1:0] state_q, state_d;
  logic [rbc_pkg::CountBits-1:0] count_q, count_d;
  logic [rbc_pkg::DelayBits-1:0] ticks_q, ticks_d;
  logic running_q, running_d;
  logic [rbc_pkg::DelayBits-1:0] next_delay;
  rbc_pkg::event_e ev;

  rbc_delay u_delay (
    .attempt_count_i(count_q),
    .initial_delay_i(cfg_i.initial_delay),
    .max_delay_i(cfg_i.max_delay),
    .delay_o(next_delay)
  );

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ticks_d = ticks_q;
    running_d = running_q;
    ev = rbc_pkg::EvNone;
    result_o.attempt_number = count_q;
    result_o.retry_delay = '0;

    if (item_i.cmd == rbc_pkg::CmdTick) begin
      if (running_q) begin
        // A loaded count of zero or one expires on the very next tick.
        if (ticks_q <= rbc_pkg::DelayBits'(1)) begin
          running_d = 1'b0;
          ticks_d = '0;
          count_d = rbc_pkg::sat_inc(count_q);
          ev = rbc_pkg::EvReconnect;
          result_o.attempt_number = count_d;
        end else begin
          ticks_d = ticks_q - 1'b1;
        end
      end
    end else if (item_i.new_state != state_q) begin
      state_d = item_i.new_state;
      if (item_i.new_state == rbc_pkg::LinkDisc) begin
        if (cfg_i.auto_enable && cfg_i.server_known) begin
          if (cfg_i.max_attempts != '0 && count_q >= cfg_i.max_attempts) begin
            ev = rbc_pkg::EvLimit;
          end else begin
            state_d = rbc_pkg::LinkReconn;
            ticks_d = next_delay;
            running_d = 1'b1;
            ev = rbc_pkg::EvScheduled;
            result_o.retry_delay = next_delay;
            result_o.attempt_number = rbc_pkg::sat_inc(count_q);
          end
        end
      end else if (item_i.new_state == rbc_pkg::LinkConnected) begin
        count_d = '0;
        running_d = 1'b0;
        ticks_d = '0;
        ev = rbc_pkg::EvConnected;
        result_o.attempt_number = '0;
      end
    end

    result_o.event_res = ev;
    result_o.link_state = state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbc_pkg::LinkDisc;
      count_q <= '0;
      ticks_q <= '0;
      running_q <= 1'b0;
    end else if (fire_i) begin
      state_q <= state_d;
      count_q <= count_d;
      ticks_q <= ticks_d;
      running_q <= running_d;
    end
  end

endmodule

>>> rtl/reconnect_backoff_controller_unit.sv
// Reconnect backoff controller: link-state reports and timer ticks in, one
// result per item out. Uses rbc_pkg, rbc_in_if, rbc_out_if, rbc_cfg, rbc_core.
//
// Channels: in_i carries items (cmd, new_state); out_o carries results
// (event_res, attempt_number, retry_delay, link_state). Both transfer on a
// rising edge with valid and ready high. Configuration is a write port
// (cfg_we_i, cfg_idx_i, cfg_wdata_i) taken at any edge with cfg_we_i high,
// and is meant to change only while the block holds no item.
// An accepted item is held in the input register; its result passes through the
// state update into the result register and from there to out_o. Throughput is
// one item per cycle while the receiver takes results, set by the single pass from the
// input register through the state update and the shift-and-clamp delay logic
// into the result register.
// Reset clears the link state to disconnected, the attempt count and the
// countdown, restores the register defaults and empties both registers.
// When the receiver stalls, the result register holds its result and the
// input register still takes one more item; after that in_i.ready drops.
module reconnect_backoff_controller_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [rbc_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [rbc_pkg::CfgDataBits-1:0] cfg_wdata_i,
  rbc_in_if.sink in_i,
  rbc_out_if.source out_o
);

  rbc_pkg::cfg_t cfg;
  rbc_pkg::in_item_t in_item_q;
  rbc_pkg::out_item_t result, out_item_q;
  logic in_vld_q, out_vld_q;
  logic advance;

  rbc_cfg u_cfg (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o(cfg)
  );

  rbc_core u_core (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_i(cfg),
    .fire_i(advance),
    .item_i(in_item_q),
    .result_o(result)
  );

  // The held item moves on whenever the result register is free or drains now.
  assign advance = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_i.payload;
    end
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.payload = out_item_q;

  a_sched_reconn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.event_res == rbc_pkg::EvScheduled
    |-> out_o.payload.link_state == rbc_pkg::LinkReconn)
    else $error("scheduled retry without reconnecting state");

  a_delay_only_sched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.event_res != rbc_pkg::EvScheduled
    |-> out_o.payload.retry_delay == '0)
    else $error("retry delay set on a result that schedules nothing");

  a_connected_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.event_res == rbc_pkg::EvConnected
    |-> out_o.payload.attempt_number == '0
        && out_o.payload.link_state == rbc_pkg::LinkConnected)
    else $error("connected result with nonzero count or wrong state");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_vld_q && out_vld_q && !out_o.ready)
    else $error("input stalled without a full pipeline");

endmodule

>>> tb/tb_backoff_checker.sv
// Result checker for the reconnect backoff controller testbench.
// Mirrors the register writes, predicts one result per accepted item and
// compares it with what the block returns. Depends on rbc_pkg, rbc_in_if, rbc_out_if.
module tb_backoff_checker
  import rbc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  rbc_in_if                     in_mon,
  rbc_out_if                    out_mon,
  output int unsigned           fail_cnt_o,
  output int unsigned           pending_o,
  output int unsigned           active_cnt_o,
  output int unsigned           item_cnt_o,
  output int unsigned           result_cnt_o,
  output int unsigned           sched_cnt_o,
  output int unsigned           reconn_cnt_o,
  output int unsigned           limit_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t                   regs;
  logic [1:0]             link_st;
  logic [CountBits-1:0]   tries;
  logic [DelayBits-1:0]   countdown;
  logic                   timer_on;
  out_item_t              predicted_outcomes[$];
  out_item_t              want;
  out_item_t              got;

  // Wait before the next retry: the first one takes the initial delay as is,
  // later ones double it per earlier attempt beyond the first and clamp to the cap.
  function automatic logic [DelayBits-1:0] backoff_delay();
    logic [2*DelayBits-1:0] grown;
    logic [CountBits-1:0]   shift;
    if (tries == '0) return regs.initial_delay;
    if (regs.initial_delay == '0) return '0;
    shift = tries - 1'b1;
    if (shift >= DelayBits) return regs.max_delay;
    grown = {{DelayBits{1'b0}}, regs.initial_delay} << shift;
    if (grown < {{DelayBits{1'b0}}, regs.max_delay}) return grown[DelayBits-1:0];
    return regs.max_delay;
  endfunction

  function automatic out_item_t step_backoff(input in_item_t it);
    out_item_t            r;
    logic [CountBits-1:0] bumped;
    bumped = (tries == CountMax) ? tries : tries + 1'b1;
    r.event_res = EvNone;
    r.attempt_number = tries;
    r.retry_delay = '0;
    if (it.cmd == CmdTick) begin
      if (timer_on) begin
        if (countdown <= 1) begin
          timer_on = 1'b0;
          countdown = '0;
          tries = bumped;
          r.event_res = EvReconnect;
          r.attempt_number = tries;
        end else begin
          countdown = countdown - 1'b1;
        end
      end
    end else if (it.new_state != link_st) begin
      link_st = it.new_state;
      if (it.new_state == LinkDisc) begin
        if (regs.auto_enable && regs.server_known) begin
          if (regs.max_attempts != '0 && tries >= regs.max_attempts) begin
            r.event_res = EvLimit;
          end else begin
            link_st = LinkReconn;
            r.retry_delay = backoff_delay();
            countdown = r.retry_delay;
            timer_on = 1'b1;
            r.event_res = EvScheduled;
            r.attempt_number = bumped;
          end
        end
      end else if (it.new_state == LinkConnected) begin
        tries = '0;
        timer_on = 1'b0;
        countdown = '0;
        r.event_res = EvConnected;
        r.attempt_number = '0;
      end
    end
    r.link_state = link_st;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.auto_enable = 1'b1;
      regs.server_known = 1'b0;
      regs.initial_delay = DelayBits'(5000);
      regs.max_delay = DelayBits'(30000);
      regs.max_attempts = 8'd5;
      link_st = LinkDisc;
      tries = '0;
      countdown = '0;
      timer_on = 1'b0;
      predicted_outcomes.delete();
      fail_cnt_o = 0;
      pending_o = 0;
      active_cnt_o = 0;
      item_cnt_o = 0;
      result_cnt_o = 0;
      sched_cnt_o = 0;
      reconn_cnt_o = 0;
      limit_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegAutoEnable:   regs.auto_enable = cfg_wdata_i[0];
          RegServerKnown:  regs.server_known = cfg_wdata_i[0];
          RegInitialDelay: regs.initial_delay = cfg_wdata_i[DelayBits-1:0];
          RegMaxDelay:     regs.max_delay = cfg_wdata_i[DelayBits-1:0];
          RegMaxAttempts:  regs.max_attempts = cfg_wdata_i[7:0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        item_cnt_o++;
        // Ticks without a running timer and repeated states leave everything as is.
        if (in_mon.payload.cmd == CmdTick ? timer_on : in_mon.payload.new_state != link_st)
          active_cnt_o++;
        want = step_backoff(in_mon.payload);
        predicted_outcomes.push_back(want);
        if (want.event_res == EvScheduled) sched_cnt_o++;
        if (want.event_res == EvReconnect) reconn_cnt_o++;
        if (want.event_res == EvLimit) limit_cnt_o++;
      end

      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.payload;
        result_cnt_o++;
        if (predicted_outcomes.size() == 0) begin
          if (fail_cnt_o < 10)
            $display("result %0d with nothing pending: ev=%0d num=%0d dly=%0d link=%0d",
                     result_cnt_o, got.event_res, got.attempt_number, got.retry_delay,
                     got.link_state);
          fail_cnt_o++;
        end else begin
          want = predicted_outcomes.pop_front();
          if (got.event_res !== want.event_res || got.attempt_number !== want.attempt_number ||
              got.retry_delay !== want.retry_delay || got.link_state !== want.link_state) begin
            if (fail_cnt_o < 10) begin
              $display("result %0d: expected ev=%0d num=%0d dly=%0d link=%0d",
                       result_cnt_o, want.event_res, want.attempt_number, want.retry_delay,
                       want.link_state);
              $display("  got ev=%0d num=%0d dly=%0d link=%0d",
                       got.event_res, got.attempt_number, got.retry_delay, got.link_state);
            end
            fail_cnt_o++;
          end
        end
      end
      pending_o = predicted_outcomes.size();
    end
  end

endmodule

>>> tb/tb_reconnect_backoff_controller_unit.sv
// Top of the reconnect backoff controller testbench: clock, reset, register
// writes and item stimulus with random idling; the verdict comes from the
// checker beside the block. Depends on rbc_pkg, the channel interfaces and tb_backoff_checker.
module tb_reconnect_backoff_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rbc_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_wdata_i;
  bit                     steady;
  int unsigned            cycle_cnt;
  int unsigned            fail_cnt, pending, active_cnt, item_cnt, result_cnt;
  int unsigned            sched_cnt, reconn_cnt, limit_cnt;

  rbc_in_if  in_ch ();
  rbc_out_if out_ch ();

  reconnect_backoff_controller_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  tb_backoff_checker i_backoff_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .active_cnt_o (active_cnt),
    .item_cnt_o   (item_cnt),
    .result_cnt_o (result_cnt),
    .sched_cnt_o  (sched_cnt),
    .reconn_cnt_o (reconn_cnt),
    .limit_cnt_o  (limit_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 31);
  endfunction

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= !take_break();
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_cnt, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_item(input logic cmd, input logic [1:0] ns);
    while (take_break()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= '{cmd: cmd, new_state: ns};
    forever begin
      @(posedge clk_i);
      if (in_ch.ready) break;
    end
    @(negedge clk_i);
  endtask

  task automatic push_report(input logic [1:0] ns);
    push_item(CmdReport, ns);
  endtask

  // The state field is don't-care on ticks, so it is filled at random.
  task automatic push_tick();
    push_item(CmdTick, 2'($urandom_range(3)));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  // Rewrites every register once the block is drained; the unused bits and
  // one write to an unmapped index carry random data.
  task automatic program_regs(input bit auto_on, input bit server_on,
                              input logic [DelayBits-1:0] first_wait,
                              input logic [DelayBits-1:0] wait_cap,
                              input logic [7:0] tries_cap);
    logic [CfgDataBits-1:0] junk;
    junk = CfgDataBits'($urandom);
    wait_idle();
    write_reg(RegAutoEnable, {junk[CfgDataBits-1:1], auto_on});
    write_reg(RegServerKnown, {~junk[CfgDataBits-1:1], server_on});
    write_reg(RegInitialDelay, first_wait);
    write_reg(RegMaxDelay, wait_cap);
    write_reg(RegMaxAttempts, {junk[CfgDataBits-1:8], tries_cap});
    write_reg(CfgIdxBits'(RegMaxAttempts + 1 + $urandom_range(2)), CfgDataBits'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Mostly full retry cycles (drop, ticks, and in half of them a new state), with some
  // random items mixed in. Runs until enough items have had an effect.
  task automatic roam(input int unsigned goal, input int unsigned tick_span,
                      input int unsigned noise_pct, input bit link_up_ok);
    int unsigned start;
    logic [1:0]  ns;
    start = active_cnt;
    while (active_cnt - start < goal) begin
      if ($urandom_range(99) >= noise_pct) begin
        push_report(LinkDisc);
        repeat ($urandom_range(tick_span, 1)) push_tick();
        case ($urandom_range(9))
          0, 1, 2: push_report(link_up_ok ? LinkConnected : LinkConnecting);
          3, 4: push_report($urandom_range(1) ? LinkConnecting : LinkReconn);
          default: ;
        endcase
      end else begin
        ns = 2'($urandom_range(3));
        if (!link_up_ok && ns == LinkConnected) ns = LinkReconn;
        push_item(1'($urandom_range(1)), ns);
      end
    end
  endtask

  initial begin
    steady = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: no server known, so drops never schedule a retry.
    push_tick();
    push_report(LinkDisc);
    push_report(LinkConnecting);
    push_report(LinkDisc);
    push_report(LinkReconn);
    push_report(LinkConnected);

    // Restart of a running timer, a timer that keeps counting through a
    // connecting report, two reconnects and then the attempt limit.
    program_regs(1'b1, 1'b1, 24'd2, 24'd5, 8'd2);
    push_report(LinkDisc);
    push_tick();
    push_report(LinkDisc);
    push_report(LinkConnecting);
    push_tick();
    push_tick();
    push_report(LinkDisc);
    push_tick();
    push_tick();
    push_report(LinkConnecting);
    push_report(LinkDisc);
    push_report(LinkConnected);

    // Zero delay fires on the very next tick.
    program_regs(1'b1, 1'b1, '0, '1, 8'd0);
    push_report(LinkDisc);
    push_tick();
    push_report(LinkConnecting);
    push_report(LinkDisc);
    push_tick();

    program_regs(1'b0, 1'b1, 24'd3, 24'd9, 8'd3);
    push_report(LinkConnecting);
    push_report(LinkDisc);

    repeat (3) begin
      program_regs($urandom_range(9) != 0, $urandom_range(9) != 0,
                   DelayBits'($urandom_range(6, 1)), DelayBits'($urandom_range(12)),
                   8'($urandom_range(6)));
      roam(40, 14, 25, 1'b1);
    end

    program_regs(1'b1, 1'b1, '1, '1, 8'hFF);
    roam(40, 3, 40, 1'b1);
    program_regs(1'b1, 1'b1, '1, '0, 8'd0);
    roam(20, 3, 40, 1'b1);

    // Build up the attempt count with short delays, then switch to wide
    // delays so the doubled term overflows or clamps at varied shifts.
    repeat (3) begin
      program_regs(1'b1, 1'b1, 24'd1, 24'd1, 8'd0);
      roam(2 * $urandom_range(28, 2), 2, 5, 1'b0);
      program_regs(1'b1, 1'b1,
                   $urandom_range(1) ? DelayBits'($urandom) : DelayBits'($urandom_range(300)),
                   DelayBits'($urandom), 8'd0);
      roam(20, 2, 40, 1'b0);
    end

    // Long unlimited run that drives the attempt count into saturation.
    program_regs(1'b1, 1'b1, 24'd1, 24'd1, 8'd0);
    roam(600, 2, 5, 1'b0);

    program_regs(1'b1, 1'b1, 24'd1, 24'd1, 8'hFF);
    push_report(LinkConnecting);
    push_report(LinkDisc);
    push_report(LinkConnected);

    steady = 1'b1;
    program_regs(1'b1, 1'b1, DelayBits'($urandom_range(4, 1)), '0, 8'd1);
    roam(40, 6, 20, 1'b1);
    program_regs(1'b1, 1'b1, DelayBits'($urandom_range(3)), DelayBits'($urandom_range(9, 2)),
                 8'($urandom_range(4, 2)));
    roam(60, 10, 20, 1'b1);
    steady = 1'b0;

    wait_idle();
    repeat (6) @(negedge clk_i);

    $display("Run covered %0d items (%0d with an effect) and %0d compared results.",
             item_cnt, active_cnt, result_cnt);
    $display("Events: %0d retries scheduled, %0d reconnect requests, %0d limit hits.",
             sched_cnt, reconn_cnt, limit_cnt);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
